### hw/rtl/identifier_symbol_table_macros.svh
// Assertion macros for the identifier symbol table.
`ifndef IDENTIFIER_SYMBOL_TABLE_MACROS_SVH
`define IDENTIFIER_SYMBOL_TABLE_MACROS_SVH
`ifndef ASSERT_OFF
`define IST_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("identifier_symbol_table: assertion failed");
`define IST_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("identifier_symbol_table: assertion failed");
`else
`define IST_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define IST_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

### hw/rtl/ist_pkg.sv
// Shared types, codes and byte classes of the identifier symbol table.
package ist_pkg;

   localparam int unsigned STATUS_W = 3;
   localparam int unsigned INDEX_W  = 10;
   localparam int unsigned LENGTH_W = 4;
   localparam logic [LENGTH_W-1:0] LEN_SAT = 4'd13;

   localparam logic [STATUS_W-1:0] ST_ENTERED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EXISTED  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_ILLEGAL  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_LONG     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd4;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_CLEAR,
      OP_BYTE,
      OP_FINISH,
      OP_HEAD,
      OP_ENTRY,
      OP_CMP,
      OP_INSERT
   } op_type;

   typedef struct packed {
      logic out_free;
      logic clear_done;
      logic to_finish;
      logic go_walk;
      logic head_valid;
      logic cmp_hit;
      logic cmp_miss;
      logic has_next;
   } status_type;

   function automatic logic is_sep(input logic [7:0] c);
      return c == 8'h20 || c == 8'h2E || c == 8'h2C || c == 8'h3B || c == 8'h3A ||
             c == 8'h3F || c == 8'h21 || c == 8'h09 || c == 8'h0A || c == 8'h00;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_word(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
             is_digit(c) || c == 8'h5F;
   endfunction

endpackage

### hw/rtl/ist_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ist_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule

### hw/rtl/ist_ctrl.sv
// Sequencer for byte intake, word judging and chain walk.
module ist_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  ist_pkg::status_type st,
   output logic                req_tready,
   output ist_pkg::op_type     op
);
   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_FINISH, S_HEAD, S_ENTRY, S_CMP, S_INSERT
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE) && st.out_free;

   always_comb begin
      op       = ist_pkg::OP_NONE;
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            op = ist_pkg::OP_CLEAR;
            if (st.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               op = ist_pkg::OP_BYTE;
               if (st.to_finish) state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            op       = ist_pkg::OP_FINISH;
            state_in = st.go_walk ? S_HEAD : S_IDLE;
         end
         S_HEAD: begin
            op       = ist_pkg::OP_HEAD;
            state_in = st.head_valid ? S_ENTRY : S_INSERT;
         end
         S_ENTRY: begin
            op       = ist_pkg::OP_ENTRY;
            state_in = S_CMP;
         end
         S_CMP: begin
            op = ist_pkg::OP_CMP;
            if (st.cmp_hit) state_in = S_IDLE;
            else if (st.cmp_miss) state_in = st.has_next ? S_ENTRY : S_INSERT;
         end
         S_INSERT: begin
            op       = ist_pkg::OP_INSERT;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

### hw/rtl/ist_dpath.sv
// Datapath: character store, bucket heads, entry table, compare and result register.
module ist_dpath #(
   parameter int unsigned STORE_SIZE  = 1024,
   parameter int unsigned BUCKETS     = 128,
   parameter int unsigned MAX_ENTRIES = 512
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  ist_pkg::op_type                        op,
   input  logic [7:0]                             text_byte,
   input  logic                                   end_of_text,
   input  logic                                   rsp_ready,
   output ist_pkg::status_type                    st,
   output logic                                   rsp_valid,
   output logic [ist_pkg::STATUS_W-1:0]           rsp_status,
   output logic [ist_pkg::INDEX_W-1:0]            rsp_index,
   output logic [ist_pkg::LENGTH_W-1:0]           rsp_length
);
   localparam int unsigned AW = $clog2(STORE_SIZE);
   localparam int unsigned PW = $clog2(STORE_SIZE + 1);
   localparam int unsigned XW = PW + 1;
   localparam int unsigned EW = $clog2(MAX_ENTRIES);
   localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
   localparam int unsigned HW = BUCKETS > 1 ? $clog2(BUCKETS) : 1;
   localparam int unsigned LW = ist_pkg::LENGTH_W;
   localparam int unsigned NBUF = 13;

   logic             in_word_ff, in_word_in;
   logic             halted_ff, halted_in;
   logic [PW-1:0]    ws_ff, ws_in;
   logic [PW-1:0]    wp_ff, wp_in;
   logic [LW-1:0]    len_ff, len_in;
   logic             bad_ff, bad_in;
   logic             dig_ff, dig_in;
   logic [HW-1:0]    hash_ff, hash_in;
   logic [7:0]       wbuf_ff [NBUF];
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [HW-1:0]    clr_ff, clr_in;
   logic             hv_ff, hv_in;
   logic [EW-1:0]    hd_ff, hd_in;
   logic [AW-1:0]    start_ff, start_in;
   logic [EW-1:0]    next_ff, next_in;
   logic             hn_ff, hn_in;
   logic [XW-1:0]    a_ff, a_in;
   logic [LW-1:0]    k_ff, k_in;
   logic             rsp_valid_ff;
   logic [ist_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [ist_pkg::INDEX_W-1:0]  rsp_index_ff;
   logic [LW-1:0]    rsp_length_ff;

   logic             buf_we;
   logic [LW-1:0]    buf_idx;
   logic             emit;
   logic [ist_pkg::STATUS_W-1:0] e_status;
   logic [PW-1:0]    e_index;
   logic [LW-1:0]    e_length;

   logic             s_we;
   logic [AW-1:0]    s_waddr, s_raddr;
   logic [7:0]       s_wdata, s_rdata;
   logic             b_we;
   logic [HW-1:0]    b_waddr, b_raddr;
   logic [EW:0]      b_wdata, b_rdata;
   logic             e_we;
   logic [EW-1:0]    e_waddr, e_raddr;
   logic [AW+EW:0]   e_wdata, e_rdata;

   logic [HW-1:0]    mod_tbl [256];

   for (genvar g = 0; g < 256; g++) begin : g_mod
      assign mod_tbl[g] = HW'(g % BUCKETS);
   end

   ist_ram #(.WIDTH(8), .DEPTH(STORE_SIZE)) u_store (
      .clock(clock), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
      .raddr(s_raddr), .rdata(s_rdata)
   );
   ist_ram #(.WIDTH(EW + 1), .DEPTH(BUCKETS)) u_bucket (
      .clock(clock), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
      .raddr(b_raddr), .rdata(b_rdata)
   );
   ist_ram #(.WIDTH(AW + EW + 1), .DEPTH(MAX_ENTRIES)) u_entry (
      .clock(clock), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
      .raddr(e_raddr), .rdata(e_rdata)
   );

   always_comb begin
      logic          new_w;
      logic [PW-1:0] ws_e;
      logic [LW-1:0] len_e;
      logic          bad_e;
      logic [HW-1:0] hash_e;
      logic [HW:0]   h_sum;
      logic [7:0]    exp_b;
      logic          oob;
      logic          eq;

      new_w  = !in_word_ff;
      ws_e   = new_w ? wp_ff : ws_ff;
      len_e  = new_w ? '0 : len_ff;
      bad_e  = new_w ? 1'b0 : bad_ff;
      hash_e = new_w ? '0 : hash_ff;
      h_sum  = {1'b0, hash_e} + {1'b0, mod_tbl[text_byte]};
      exp_b  = (k_ff == len_ff || k_ff >= LW'(NBUF)) ? 8'h00 : wbuf_ff[k_ff];
      oob    = a_ff >= XW'(STORE_SIZE);
      eq     = !oob && s_rdata == exp_b;

      in_word_in = in_word_ff;
      halted_in  = halted_ff;
      ws_in      = ws_ff;
      wp_in      = wp_ff;
      len_in     = len_ff;
      bad_in     = bad_ff;
      dig_in     = dig_ff;
      hash_in    = hash_ff;
      cnt_in     = cnt_ff;
      clr_in     = clr_ff;
      hv_in      = hv_ff;
      hd_in      = hd_ff;
      start_in   = start_ff;
      next_in    = next_ff;
      hn_in      = hn_ff;
      a_in       = a_ff;
      k_in       = k_ff;
      buf_we     = 1'b0;
      buf_idx    = len_e;
      emit       = 1'b0;
      e_status   = ist_pkg::ST_ENTERED;
      e_index    = ws_ff;
      e_length   = len_ff;
      s_we       = 1'b0;
      s_waddr    = wp_ff[AW-1:0];
      s_wdata    = 8'h00;
      s_raddr    = AW'(a_ff + XW'(1));
      b_we       = 1'b0;
      b_waddr    = hash_ff;
      b_wdata    = {1'b1, cnt_ff[EW-1:0]};
      b_raddr    = hash_ff;
      e_we       = 1'b0;
      e_waddr    = cnt_ff[EW-1:0];
      e_wdata    = {hv_ff, hd_ff, ws_ff[AW-1:0]};
      e_raddr    = next_ff;
      st         = '0;
      st.out_free = !rsp_valid_ff || rsp_ready;

      case (op)
         ist_pkg::OP_CLEAR: begin
            b_we          = 1'b1;
            b_waddr       = clr_ff;
            b_wdata       = '0;
            clr_in        = clr_ff + HW'(1);
            st.clear_done = clr_ff == HW'(BUCKETS - 1);
         end
         ist_pkg::OP_BYTE: begin
            if (!halted_ff) begin
               if (ist_pkg::is_sep(text_byte)) begin
                  st.to_finish = in_word_ff;
               end else begin
                  ws_in  = ws_e;
                  len_in = len_e;
                  bad_in = bad_e;
                  hash_in = hash_e;
                  if (new_w) dig_in = ist_pkg::is_digit(text_byte);
                  if (wp_ff >= PW'(STORE_SIZE)) begin
                     halted_in  = 1'b1;
                     in_word_in = 1'b0;
                     emit       = 1'b1;
                     e_status   = ist_pkg::ST_OVERFLOW;
                     e_index    = ws_e;
                     e_length   = len_e;
                  end else begin
                     in_word_in = 1'b1;
                     s_we       = 1'b1;
                     s_wdata    = text_byte;
                     wp_in      = wp_ff + PW'(1);
                     bad_in     = bad_e || !ist_pkg::is_word(text_byte);
                     buf_we     = len_e < ist_pkg::LEN_SAT;
                     if (len_e < ist_pkg::LEN_SAT) len_in = len_e + LW'(1);
                     hash_in    = h_sum >= (HW + 1)'(BUCKETS) ?
                                  HW'(h_sum - (HW + 1)'(BUCKETS)) : HW'(h_sum);
                     st.to_finish = end_of_text;
                  end
               end
            end
         end
         ist_pkg::OP_FINISH: begin
            in_word_in = 1'b0;
            if (len_ff >= ist_pkg::LEN_SAT) begin
               wp_in    = ws_ff;
               emit     = 1'b1;
               e_status = ist_pkg::ST_LONG;
            end else if (bad_ff || dig_ff) begin
               wp_in    = ws_ff;
               emit     = 1'b1;
               e_status = ist_pkg::ST_ILLEGAL;
            end else if (wp_ff >= PW'(STORE_SIZE)) begin
               halted_in = 1'b1;
               emit      = 1'b1;
               e_status  = ist_pkg::ST_OVERFLOW;
            end else begin
               s_we       = 1'b1;
               st.go_walk = 1'b1;
            end
         end
         ist_pkg::OP_HEAD: begin
            hv_in         = b_rdata[EW];
            hd_in         = b_rdata[EW-1:0];
            e_raddr       = b_rdata[EW-1:0];
            st.head_valid = b_rdata[EW];
         end
         ist_pkg::OP_ENTRY: begin
            start_in = e_rdata[AW-1:0];
            next_in  = e_rdata[AW+EW-1:AW];
            hn_in    = e_rdata[AW+EW];
            s_raddr  = e_rdata[AW-1:0];
            a_in     = XW'(e_rdata[AW-1:0]);
            k_in     = '0;
         end
         ist_pkg::OP_CMP: begin
            if (eq && k_ff == len_ff) begin
               st.cmp_hit = 1'b1;
               wp_in      = ws_ff;
               emit       = 1'b1;
               e_status   = ist_pkg::ST_EXISTED;
               e_index    = PW'(start_ff);
            end else if (!eq) begin
               st.cmp_miss = 1'b1;
               st.has_next = hn_ff;
            end else begin
               k_in = k_ff + LW'(1);
               a_in = a_ff + XW'(1);
            end
         end
         ist_pkg::OP_INSERT: begin
            if (cnt_ff >= CW'(MAX_ENTRIES)) begin
               halted_in = 1'b1;
               emit      = 1'b1;
               e_status  = ist_pkg::ST_OVERFLOW;
            end else begin
               e_we     = 1'b1;
               b_we     = 1'b1;
               cnt_in   = cnt_ff + CW'(1);
               wp_in    = ws_ff + PW'(len_ff) + PW'(1);
               emit     = 1'b1;
               e_status = ist_pkg::ST_ENTERED;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_word_ff   <= 1'b0;
         halted_ff    <= 1'b0;
         ws_ff        <= '0;
         wp_ff        <= '0;
         len_ff       <= '0;
         bad_ff       <= 1'b0;
         dig_ff       <= 1'b0;
         hash_ff      <= '0;
         cnt_ff       <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_word_ff   <= in_word_in;
         halted_ff    <= halted_in;
         ws_ff        <= ws_in;
         wp_ff        <= wp_in;
         len_ff       <= len_in;
         bad_ff       <= bad_in;
         dig_ff       <= dig_in;
         hash_ff      <= hash_in;
         cnt_ff       <= cnt_in;
         clr_ff       <= clr_in;
         if (emit) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
      hv_ff    <= hv_in;
      hd_ff    <= hd_in;
      start_ff <= start_in;
      next_ff  <= next_in;
      hn_ff    <= hn_in;
      a_ff     <= a_in;
      k_ff     <= k_in;
      if (buf_we) wbuf_ff[buf_idx] <= text_byte;
      if (emit) begin
         rsp_status_ff <= e_status;
         rsp_index_ff  <= ist_pkg::INDEX_W'(e_index);
         rsp_length_ff <= e_length;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_index  = rsp_index_ff;
   assign rsp_length = rsp_length_ff;
endmodule

### hw/rtl/identifier_symbol_table.sv
// Identifier symbol table: byte-serial word splitter with chained hash lookup.
// Bytes are taken only in the idle state, while the result register is empty or being read.
// A word end is judged in the finish state; the bucket head is then read, each chain entry
// compared is read and checked one store byte per cycle, and the insert state enters a new word.
// Reset is synchronous; afterwards a clearing pass empties all BUCKETS bucket heads,
// during which no word is accepted.
module identifier_symbol_table #(
   parameter int unsigned STORE_SIZE  = 1024,
   parameter int unsigned BUCKETS     = 128,
   parameter int unsigned MAX_ENTRIES = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tlast,   // end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [9:0] store_index, [13:10] word_length, [15:14] zero
   output logic [2:0]  rsp_tuser    // [2:0] status
);
   `include "identifier_symbol_table_macros.svh"

   ist_pkg::op_type     op;
   ist_pkg::status_type st;
   logic [ist_pkg::INDEX_W-1:0]  rsp_index;
   logic [ist_pkg::LENGTH_W-1:0] rsp_length;

   ist_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .st(st),
      .req_tready(req_tready), .op(op)
   );

   ist_dpath #(
      .STORE_SIZE(STORE_SIZE), .BUCKETS(BUCKETS), .MAX_ENTRIES(MAX_ENTRIES)
   ) u_dpath (
      .clock(clock), .reset(reset), .op(op), .text_byte(req_tdata),
      .end_of_text(req_tlast), .rsp_ready(rsp_tready), .st(st),
      .rsp_valid(rsp_tvalid), .rsp_status(rsp_tuser), .rsp_index(rsp_index),
      .rsp_length(rsp_length)
   );

   assign rsp_tdata = {2'b00, rsp_length, rsp_index};

   `IST_ASSERT_NEXT(a_halt_silent, clock, reset,
      rsp_tvalid && rsp_tready && rsp_tuser == ist_pkg::ST_OVERFLOW, !rsp_tvalid)
   `IST_ASSERT_IMPLIES(a_len_sat, clock, reset, rsp_tvalid,
      rsp_tdata[13:10] <= ist_pkg::LEN_SAT && rsp_tuser <= ist_pkg::ST_OVERFLOW)
   `IST_ASSERT_IMPLIES(a_found_short, clock, reset,
      rsp_tvalid && (rsp_tuser == ist_pkg::ST_ENTERED || rsp_tuser == ist_pkg::ST_EXISTED),
      rsp_tdata[13:10] < ist_pkg::LEN_SAT && rsp_tdata[13:10] != 4'd0)
endmodule

### bench/tb.sv
// Testbench for identifier_symbol_table: byte stream in, word lookup results checked.
`timescale 1ns / 100ps
module tb;

   typedef struct {
      logic [ist_pkg::STATUS_W-1:0] status;
      logic [ist_pkg::INDEX_W-1:0]  index;
      logic [ist_pkg::LENGTH_W-1:0] length;
   } lookup_type;

   localparam int STORE_SIZE = 1024;
   localparam int BUCKETS = 128;
   localparam int MAX_ENTRIES = 512;
   localparam int WATCHDOG_LIMIT = 40000;

   localparam int IDLE_NONE = 0;
   localparam int IDLE_SEND = 1;
   localparam int IDLE_RECV = 2;
   localparam int IDLE_BOTH = 3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] text_byte
   logic        req_tlast = 1'b0;    // end_of_text
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;           // [9:0] store_index, [13:10] word_length, [15:14] zero
   logic [2:0]  rsp_tuser;           // [2:0] status

   identifier_symbol_table DUT (.*);

   always #6 clock = ~clock;

   lookup_type lookups_due[$];
   int idle_mode = IDLE_NONE;
   int errors = 0;
   int bytes_sent = 0;
   int words_checked = 0;
   int status_seen[5];
   int quiet_cycles = 0;

   // symbol table image
   bit       sym_in_word, sym_halted, sym_bad, sym_digit_first;
   int       sym_start, sym_wp, sym_len, sym_sum, sym_entries;
   bit [7:0] sym_chars[STORE_SIZE];
   int       sym_head[BUCKETS];
   bit       sym_head_ok[BUCKETS];
   int       sym_entry_start[MAX_ENTRIES];
   int       sym_entry_next[MAX_ENTRIES];
   bit       sym_entry_more[MAX_ENTRIES];

   function automatic bit is_separator(bit [7:0] c);
      return c inside {" ", ".", ",", ";", ":", "?", "!", 8'h09, 8'h0A, 8'h00};
   endfunction

   function automatic bit is_numeral(bit [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_ident_char(bit [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || is_numeral(c) || c == "_";
   endfunction

   function automatic lookup_type make_lookup(logic [2:0] st, int idx, int len);
      lookup_type r;
      r.status = st;
      r.index = idx[9:0];
      r.length = (len > 13) ? 4'd13 : len[3:0];
      return r;
   endfunction

   function automatic lookup_type halt_table();
      sym_halted = 1;
      sym_in_word = 0;
      return make_lookup(ist_pkg::ST_OVERFLOW, sym_start, sym_len);
   endfunction

   function automatic bit words_match(int a, int b, int len);
      for (int k = 0; k <= len; k++) begin
         if (a + k >= STORE_SIZE || b + k >= STORE_SIZE) return 0;
         if (sym_chars[a + k] != sym_chars[b + k]) return 0;
      end
      return 1;
   endfunction

   function automatic lookup_type close_word();
      int h, e;
      sym_in_word = 0;
      if (sym_len >= 13) begin
         sym_wp = sym_start;
         return make_lookup(ist_pkg::ST_LONG, sym_start, sym_len);
      end
      if (sym_bad || sym_digit_first) begin
         sym_wp = sym_start;
         return make_lookup(ist_pkg::ST_ILLEGAL, sym_start, sym_len);
      end
      if (sym_wp >= STORE_SIZE) return halt_table();
      sym_chars[sym_wp] = 8'h00;
      h = sym_sum % BUCKETS;
      if (sym_head_ok[h]) begin
         e = sym_head[h];
         for (int n = 0; n < MAX_ENTRIES && e < MAX_ENTRIES; n++) begin
            if (words_match(sym_entry_start[e], sym_start, sym_len)) begin
               sym_wp = sym_start;
               return make_lookup(ist_pkg::ST_EXISTED, sym_entry_start[e], sym_len);
            end
            if (!sym_entry_more[e]) break;
            e = sym_entry_next[e];
         end
      end
      if (sym_entries >= MAX_ENTRIES) return halt_table();
      e = sym_entries++;
      sym_entry_start[e] = sym_start;
      sym_entry_next[e] = sym_head[h];
      sym_entry_more[e] = sym_head_ok[h];
      sym_head[h] = e;
      sym_head_ok[h] = 1;
      sym_wp = sym_start + sym_len + 1;
      return make_lookup(ist_pkg::ST_ENTERED, sym_start, sym_len);
   endfunction

   function automatic bit predict_lookup(bit [7:0] c, bit last, output lookup_type r);
      if (sym_halted) return 0;
      if (is_separator(c)) begin
         if (!sym_in_word) return 0;
         r = close_word();
         return 1;
      end
      if (!sym_in_word) begin
         sym_in_word = 1;
         sym_start = sym_wp;
         sym_len = 0;
         sym_bad = 0;
         sym_sum = 0;
         sym_digit_first = is_numeral(c);
      end
      if (sym_wp >= STORE_SIZE) begin
         r = halt_table();
         return 1;
      end
      sym_chars[sym_wp++] = c;
      if (!is_ident_char(c)) sym_bad = 1;
      if (sym_len < 13) sym_len++;
      sym_sum = (sym_sum + c) & 12'hFFF;
      if (!last) return 0;
      r = close_word();
      return 1;
   endfunction

   task automatic send_byte(bit [7:0] c, bit last);
      lookup_type r;
      int idle_pct;
      idle_pct = (idle_mode == IDLE_SEND) ? 80 : (idle_mode == IDLE_BOTH) ? 13 : 0;
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= c;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
      if (predict_lookup(c, last, r)) lookups_due.push_back(r);
   endtask

   task automatic send_text(string s, bit last_at_end);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], last_at_end && i == s.len() - 1);
   endtask

   function automatic string random_ident(int len);
      string s = "";
      bit [7:0] c;
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(3))
            0: c = "a" + $urandom_range(25);
            1: c = "A" + $urandom_range(25);
            2: c = (i == 0) ? "_" : "0" + $urandom_range(9);
            default: c = "z" - $urandom_range(5);
         endcase
         s = {s, string'(c)};
      end
      return s;
   endfunction

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (lookups_due.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic test_directed();
      send_text(" ab ba ab.", 0);
      send_text("9x a$b,", 0);
      send_text("abcdefghijklm abcdefghijkl;", 0);
      send_text("_Z9:", 0);
      send_byte(8'hFF, 0);
      send_byte(8'h00, 0);
      send_text("q", 1);
      wait_drained();
   endtask

   task automatic test_random(int mode, int count);
      string vocab[$];
      string w;
      bit [7:0] seps[10] = '{" ", ".", ",", ";", ":", "?", "!", 8'h09, 8'h0A, 8'h00};
      int sent;
      idle_mode = mode;
      for (int i = 0; i < 24; i++) vocab.push_back(random_ident($urandom_range(1, 6)));
      vocab.push_back("ab");
      vocab.push_back("ba");
      sent = 0;
      while (sent < count) begin
         case ($urandom_range(19))
            0: w = random_ident($urandom_range(1, 12));
            1: w = random_ident($urandom_range(13, 16));
            2: begin
               w = random_ident($urandom_range(1, 5));
               w[$urandom_range(w.len() - 1)] = $urandom_range(255);
            end
            3: w = {string'(8'("0" + $urandom_range(9))), random_ident($urandom_range(0, 4))};
            4: begin
               send_byte($urandom_range(255), $urandom_range(3) == 0);
               sent++;
               continue;
            end
            default: w = vocab[$urandom_range(vocab.size() - 1)];
         endcase
         for (int i = 0; i < w.len(); i++)
            if (w[i] != 8'h00) begin
               send_byte(w[i], i == w.len() - 1 && $urandom_range(9) == 0);
               sent++;
            end
         send_byte(seps[$urandom_range(9)], 0);
         sent++;
      end
      wait_drained();
   endtask

   task automatic test_overflow();
      idle_mode = IDLE_BOTH;
      while (!sym_halted) send_text({"o", random_ident($urandom_range(6, 11)), " "}, 0);
      send_text("late words go nowhere ", 0);
      wait_drained();
   endtask

   always @(posedge clock) begin
      if (idle_mode == IDLE_RECV) rsp_tready <= $urandom_range(99) >= 80;
      else if (idle_mode == IDLE_BOTH) rsp_tready <= $urandom_range(99) >= 13;
      else rsp_tready <= 1'b1;
   end

   always @(posedge clock) begin
      lookup_type want;
      if (rsp_tvalid && rsp_tready && !reset) begin
         if (lookups_due.size() == 0) begin
            $error("result with nothing expected: status %0d index %0d", rsp_tuser,
                   rsp_tdata[9:0]);
            errors++;
         end else begin
            want = lookups_due.pop_front();
            words_checked++;
            if (want.status <= ist_pkg::ST_OVERFLOW) status_seen[want.status]++;
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tuser);
               errors++;
            end
            if (rsp_tdata[9:0] !== want.index) begin
               $error("store_index: expected %0d, got %0d", want.index, rsp_tdata[9:0]);
               errors++;
            end
            if (rsp_tdata[13:10] !== want.length) begin
               $error("word_length: expected %0d, got %0d", want.length, rsp_tdata[13:10]);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCHDOG_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(IDLE_NONE, 250);
      test_random(IDLE_SEND, 200);
      test_random(IDLE_RECV, 200);
      test_random(IDLE_BOTH, 250);
      test_overflow();
      wait_drained();
      if (lookups_due.size() != 0) errors++;
      $display("sent %0d text bytes, checked %0d words: %0d entered, %0d repeats,",
               bytes_sent, words_checked, status_seen[0], status_seen[1]);
      $display("%0d illegal, %0d too long, %0d overflow, under four idle patterns",
               status_seen[2], status_seen[3], status_seen[4]);
      if (errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule
